[src/sse_pkg.sv]
// Shared types and constants for the subset-sum enumerator core.
// No dependencies; used by sse_csr and subset_sum_enumerator_core.
package sse_pkg;

   // Operation codes carried by an input item
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_FIND = 1'b1;

   // Register file layout
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_TARGET_SUM = 1'b0;

   typedef struct packed {
      logic               operation;
      logic signed [15:0] element_value;
      logic               last_element;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] subset_mask;
      logic [4:0]  subset_size;
   } rsp_type;

   typedef struct packed {
      logic                  psel;
      logic                  penable;
      logic                  pwrite;
      logic [CSR_ADDR_W-1:0] paddr;
      logic [31:0]           pwdata;
   } csr_req_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SUM   = 4'b0010,
      ST_CHECK = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

[src/sse_csr.sv]
// Configuration register block: holds target_sum behind an APB-style port.
// Depends on sse_pkg for the request struct and register index.
module sse_csr (
   input  logic                clock,
   input  logic                reset,
   input  sse_pkg::csr_req_type csr_req,
   output logic [31:0]         prdata,
   output logic signed [31:0]  target_sum
);

   logic signed [31:0] target_ff;
   logic signed [31:0] target_in;
   logic               sel_target;
   logic               wr_access;

   // Decode the word index and the access phase of a write
   assign sel_target = (csr_req.paddr[sse_pkg::CSR_ADDR_W-1] == sse_pkg::REG_TARGET_SUM);
   assign wr_access  = csr_req.psel & csr_req.penable & csr_req.pwrite;

   always_comb begin
      target_in = target_ff;
      if (wr_access && sel_target) begin
         target_in = csr_req.pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else begin
         target_ff <= target_in;
      end
   end

   // Read back the selected register, zero beyond the list
   assign prdata     = sel_target ? target_ff : 32'd0;
   assign target_sum = target_ff;

endmodule

[src/subset_sum_enumerator_core.sv]
// Subset-sum enumerator: brute-force scan of subset masks with one shared adder.
// Depends on sse_pkg and sse_csr.
//
// Usage: write target_sum through the csr_ port while idle. Send load items
// (operation 0), one element each, with last_element on the final one; a load
// after a completed set starts a new set, and elements past MAX_ELEMENTS are
// dropped. Each find item (operation 1) resumes the mask scan in ascending
// order and returns one rsp_ item: found with mask and size, or not-found.
// A load returns nothing. For each mask that a find examines, the single
// adder walks the set's elements one per cycle, adding those in the mask,
// then the sum is compared with target_sum; an empty set skips the walk.
// req_stall is high while a find is in progress; a new item is taken while a
// result still waits in the output register, but a finished find holds until
// that register is free. rsp_stall holds rsp_valid and rsp_data unchanged.
// Synchronous reset clears the set, the scan position, target_sum and any
// pending result; element values stay undefined until loaded.
module subset_sum_enumerator_core #(
   parameter int MAX_ELEMENTS  = 16,
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // input item channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sse_pkg::req_type                  req_data,
   // result item channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sse_pkg::rsp_type                  rsp_data,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sse_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int IDXW  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNTW  = $clog2(MAX_ELEMENTS + 1);
   localparam int MASKW = MAX_ELEMENTS + 1;
   localparam int SUMW  = ELEMENT_WIDTH + CNTW;
   localparam int CMPW  = (SUMW > 33) ? SUMW : 33;

   sse_pkg::csr_req_type csr_req;
   logic signed [31:0]   target_sum;

   // Bundle the configuration port for the register block
   assign csr_req.psel    = csr_psel;
   assign csr_req.penable = csr_penable;
   assign csr_req.pwrite  = csr_pwrite;
   assign csr_req.paddr   = csr_paddr;
   assign csr_req.pwdata  = csr_pwdata;
   assign csr_pready      = 1'b1;

   sse_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_req    (csr_req),
      .prdata     (csr_prdata),
      .target_sum (target_sum)
   );

   // Element store, written by loads, read one entry per cycle by the scan
   logic signed [ELEMENT_WIDTH-1:0] store_ff [MAX_ELEMENTS];
   logic                            store_we;
   logic [IDXW-1:0]                 store_idx;
   logic signed [ELEMENT_WIDTH-1:0] store_wdata;

   sse_pkg::state_type      state_ff, state_in;
   logic [CNTW-1:0]         count_ff, count_in;
   logic                    complete_ff, complete_in;
   logic [MASKW-1:0]        next_mask_ff, next_mask_in;
   logic [MASKW-1:0]        mask_ff, mask_in;
   logic [IDXW-1:0]         j_ff, j_in;
   logic signed [SUMW-1:0]  sum_ff, sum_in;
   logic [CNTW-1:0]         pop_ff, pop_in;
   logic                    hit_ff, hit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   sse_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                    req_accept;
   logic                    out_free;
   logic                    begin_mask;
   logic                    more_masks;
   logic                    last_j;
   logic                    sum_hit;
   logic [MASKW-1:0]        limit;
   logic [CNTW-1:0]         eff_count;
   logic signed [SUMW-1:0]  elem_ext;

   assign req_stall  = (state_ff != sse_pkg::ST_IDLE);
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign limit      = MASKW'(1) << count_ff;
   assign more_masks = (next_mask_ff < limit);
   assign last_j     = ((CNTW'(j_ff) + CNTW'(1)) == count_ff);
   assign elem_ext   = SUMW'(store_ff[j_ff]);
   assign sum_hit    = (CMPW'(sum_ff) == CMPW'(target_sum));
   assign eff_count  = complete_ff ? '0 : count_ff;

   assign store_idx   = eff_count[IDXW-1:0];
   assign store_wdata = ELEMENT_WIDTH'(32'($unsigned(req_data.element_value)));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      complete_in  = complete_ff;
      next_mask_in = next_mask_ff;
      mask_in      = mask_ff;
      j_in         = j_ff;
      sum_in       = sum_ff;
      pop_in       = pop_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      store_we     = 1'b0;
      begin_mask   = 1'b0;

      // Drop a delivered result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sse_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_data.operation == sse_pkg::OP_LOAD) begin
                  complete_in = 1'b0;
                  count_in    = eff_count;
                  if (eff_count < CNTW'(MAX_ELEMENTS)) begin
                     store_we = 1'b1;
                     count_in = eff_count + CNTW'(1);
                  end
                  if (req_data.last_element) begin
                     complete_in  = 1'b1;
                     next_mask_in = '0;
                  end
               end else if (complete_ff && more_masks) begin
                  begin_mask = 1'b1;
               end else begin
                  hit_in   = 1'b0;
                  state_in = sse_pkg::ST_DONE;
               end
            end
         end
         sse_pkg::ST_SUM: begin
            // Walk one element per cycle, adding it if it is in the current mask
            if (mask_ff[j_ff]) begin
               sum_in = sum_ff + elem_ext;
               pop_in = pop_ff + CNTW'(1);
            end
            if (last_j) begin
               state_in = sse_pkg::ST_CHECK;
            end else begin
               j_in = j_ff + IDXW'(1);
            end
         end
         sse_pkg::ST_CHECK: begin
            if (sum_hit) begin
               hit_in   = 1'b1;
               state_in = sse_pkg::ST_DONE;
            end else if (more_masks) begin
               begin_mask = 1'b1;
            end else begin
               hit_in   = 1'b0;
               state_in = sse_pkg::ST_DONE;
            end
         end
         sse_pkg::ST_DONE: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.found       = hit_ff;
               rsp_data_in.subset_mask = hit_ff ? 16'(mask_ff) : 16'd0;
               rsp_data_in.subset_size = hit_ff ? 5'(pop_ff) : 5'd0;
               state_in                = sse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sse_pkg::ST_IDLE;
         end
      endcase

      // Advance to the next mask in ascending order
      if (begin_mask) begin
         mask_in      = next_mask_ff;
         next_mask_in = next_mask_ff + MASKW'(1);
         j_in         = '0;
         sum_in       = '0;
         pop_in       = '0;
         state_in     = (count_ff == '0) ? sse_pkg::ST_CHECK : sse_pkg::ST_SUM;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sse_pkg::ST_IDLE;
         count_ff     <= '0;
         complete_ff  <= 1'b0;
         next_mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         complete_ff  <= complete_in;
         next_mask_ff <= next_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      j_ff        <= j_in;
      sum_ff      <= sum_in;
      pop_ff      <= pop_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Element store write
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= store_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for subset_sum_enumerator_core: directed script, then random sets.
// Depends on sse_pkg and the core RTL; prediction is done here in SystemVerilog.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 16;
   localparam int LOAD_WIDTH = 16;
   localparam int ADDR_W = sse_pkg::CSR_ADDR_W;
   localparam logic [ADDR_W-1:0] TARGET_ADDR = ADDR_W'(4 * sse_pkg::REG_TARGET_SUM);
   localparam sse_pkg::rsp_type NOT_FOUND = '0;
   localparam int RANDOM_ITEMS = 80;
   localparam int SCRIPT_ROWS = 23;

   // One directed step: optional target change while idle, one item, optional typed answer
   typedef struct {
      bit                 retarget;
      logic signed [31:0] target;
      sse_pkg::req_type   item;
      bit                 typed;
      sse_pkg::rsp_type   want;
   } script_row_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   sse_pkg::req_type      req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   sse_pkg::rsp_type      rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0]     csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predicted state of the core
   logic signed [15:0] held_elems [CAPACITY];
   int                 held_count = 0;
   bit                 set_ready  = 1'b0;
   int                 scan_next  = 0;
   logic signed [31:0] goal       = '0;

   // Answers owed by the core, oldest first
   sse_pkg::rsp_type answers [$];

   bit no_idle     = 1'b0;
   int hold_left   = 0;
   int mismatches  = 0;
   int loads_sent  = 0;
   int finds_sent  = 0;
   int hits_seen   = 0;
   int targets_set = 0;

   subset_sum_enumerator_core #(
      .MAX_ELEMENTS  (CAPACITY),
      .ELEMENT_WIDTH (LOAD_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("** subset_sum_enumerator_core: FAILED **");
      $finish;
   end

   // Store one element; a load after a completed set starts a new set
   function automatic void store_element(sse_pkg::req_type item);
      if (set_ready) begin
         held_count = 0;
         set_ready  = 1'b0;
      end
      if (held_count < CAPACITY) begin
         held_elems[held_count] = item.element_value;
         held_count++;
      end
      if (item.last_element) begin
         set_ready = 1'b1;
         scan_next = 0;
      end
   endfunction

   // Resume the ascending mask scan and stop at the next subset that hits the goal
   function automatic sse_pkg::rsp_type search_next_subset();
      sse_pkg::rsp_type ans;
      longint           total;
      int               mask;
      ans = NOT_FOUND;
      if (!set_ready) return ans;
      while (scan_next < (1 << held_count)) begin
         mask = scan_next;
         scan_next++;
         total = 0;
         for (int j = 0; j < held_count; j++)
            if (mask[j]) total += held_elems[j];
         if (total == goal) begin
            ans.found       = 1'b1;
            ans.subset_mask = mask[15:0];
            ans.subset_size = 5'($countones(mask));
            return ans;
         end
      end
      return ans;
   endfunction

   // Offer one item after a random gap, hold it until taken, then update the prediction
   task automatic send_item(input sse_pkg::req_type item, input bit typed,
                            input sse_pkg::rsp_type want,
                            output sse_pkg::rsp_type predicted);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predicted = NOT_FOUND;
      if (item.operation == sse_pkg::OP_LOAD) begin
         store_element(item);
         loads_sent++;
      end else begin
         predicted = search_next_subset();
         answers.push_back(typed ? want : predicted);
         finds_sent++;
      end
   endtask

   // Drop valid and let every owed answer drain before touching the register
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write target_sum with a setup and an access phase, then read it back
   task automatic write_target(input logic signed [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TARGET_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      goal = value;
      targets_set++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         $error("target_sum readback: expected %h, got %h", value, csr_prdata);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Load one random set, aim the target at it, then search it with finds
   task automatic run_random_set(input bit force_big);
      int                 n;
      int                 pick;
      int                 acc;
      int                 find_cap;
      logic signed [15:0] vals [$];
      logic signed [31:0] tgt;
      sse_pkg::req_type   item;
      sse_pkg::rsp_type   got;
      pick = $urandom_range(0, 99);
      if (force_big || pick >= 95) n = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      else if (pick >= 80)         n = $urandom_range(7, 10);
      else                         n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 1) == 0) begin
            acc = $urandom_range(0, 40);
            vals.push_back(16'(acc - 20));
         end else begin
            vals.push_back(16'($urandom()));
         end
      end
      // choose a goal: mostly a real subset sum so matches are common
      pick = $urandom_range(0, 99);
      acc = 0;
      if (n > CAPACITY) begin
         tgt = vals[0] + vals[1];
      end else if (pick < 65) begin
         foreach (vals[i]) if ($urandom_range(0, 1) == 1) acc += vals[i];
         tgt = acc;
      end else if (pick < 75) begin
         tgt = 0;
      end else begin
         tgt = $urandom();
      end
      wait_idle();
      write_target(tgt);
      no_idle = ($urandom_range(0, 3) == 0);
      // load the set, with a stray find now and then
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            item = {sse_pkg::OP_FIND, 16'($urandom()), 1'($urandom())};
            send_item(item, 1'b0, NOT_FOUND, got);
         end
         item = {sse_pkg::OP_LOAD, vals[i], (i == n - 1)};
         send_item(item, 1'b0, NOT_FOUND, got);
      end
      // search until a miss or the find cap: 1 find above 10 elements, 3 above 6, else 8
      find_cap = (n > 10) ? 1 : ((n > 6) ? 3 : 8);
      for (int k = 0; k < find_cap; k++) begin
         item = {sse_pkg::OP_FIND, 16'($urandom()), 1'($urandom())};
         send_item(item, 1'b0, NOT_FOUND, got);
         if (!got.found) begin
            if ($urandom_range(0, 1) == 1) send_item(item, 1'b0, NOT_FOUND, got);
            break;
         end
      end
   endtask

   // Take each answer, compare with the oldest owed one, then stall for a random while
   always @(posedge clock) begin
      sse_pkg::rsp_type want;
      if (reset) begin
         hold_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               $error("unexpected answer: found %b mask %h size %0d",
                      rsp_data.found, rsp_data.subset_mask, rsp_data.subset_size);
               mismatches++;
            end else begin
               want = answers.pop_front();
               if (rsp_data.found !== want.found) begin
                  $error("found: expected %b, got %b", want.found, rsp_data.found);
                  mismatches++;
               end
               if (rsp_data.subset_mask !== want.subset_mask) begin
                  $error("subset_mask: expected %h, got %h",
                         want.subset_mask, rsp_data.subset_mask);
                  mismatches++;
               end
               if (rsp_data.subset_size !== want.subset_size) begin
                  $error("subset_size: expected %0d, got %0d",
                         want.subset_size, rsp_data.subset_size);
                  mismatches++;
               end
               if (want.found) hits_seen++;
            end
            hold_left = no_idle ? 0 : $urandom_range(0, 19);
         end else if (rsp_valid && hold_left != 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   initial begin
      script_row_type script [SCRIPT_ROWS] = '{
         // find before any set exists
         '{0, 0, {sse_pkg::OP_FIND, 16'sh7FFF, 1'b0}, 1, NOT_FOUND},
         // two elements cancel; empty subset comes first with goal zero
         '{0, 0, {sse_pkg::OP_LOAD, 16'sd5, 1'b0}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_LOAD, -16'sd5, 1'b1}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh0000, 1'b0}, 1, {1'b1, 16'h0000, 5'd0}},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh1234, 1'b0}, 1, {1'b1, 16'h0003, 5'd2}},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh0000, 1'b0}, 1, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh8000, 1'b1}, 1, NOT_FOUND},
         // element extremes
         '{1, 32'sd32767, {sse_pkg::OP_LOAD, 16'sh7FFF, 1'b0}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_LOAD, 16'sh8000, 1'b0}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_LOAD, 16'shFFFF, 1'b1}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh5A5A, 1'b0}, 1, {1'b1, 16'h0001, 5'd1}},
         '{0, 0, {sse_pkg::OP_FIND, 16'shA5A5, 1'b0}, 1, NOT_FOUND},
         // sum below the element range
         '{1, -32'sd32769, {sse_pkg::OP_LOAD, 16'sh8000, 1'b0}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_LOAD, 16'shFFFF, 1'b1}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh0000, 1'b0}, 1, {1'b1, 16'h0003, 5'd2}},
         // target extremes that no subset reaches
         '{1, 32'sh7FFFFFFF, {sse_pkg::OP_LOAD, 16'sd7, 1'b1}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh0000, 1'b0}, 1, NOT_FOUND},
         '{1, 32'sh80000000, {sse_pkg::OP_LOAD, 16'sd1, 1'b1}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_FIND, 16'shFFFF, 1'b1}, 1, NOT_FOUND},
         // single zero element: empty subset, then the element itself
         '{1, 0, {sse_pkg::OP_LOAD, 16'sd0, 1'b1}, 0, NOT_FOUND},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh0000, 1'b0}, 1, {1'b1, 16'h0000, 5'd0}},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh0000, 1'b0}, 1, {1'b1, 16'h0001, 5'd1}},
         '{0, 0, {sse_pkg::OP_FIND, 16'sh0000, 1'b0}, 1, NOT_FOUND}
      };
      sse_pkg::rsp_type got;
      int               set_idx;
      int               start_items;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed script
      foreach (script[i]) begin
         if (script[i].retarget) begin
            wait_idle();
            write_target(script[i].target);
         end
         send_item(script[i].item, script[i].typed, script[i].want, got);
      end

      // random sets until enough items went in
      start_items = loads_sent + finds_sent;
      set_idx = 0;
      while (loads_sent + finds_sent - start_items < RANDOM_ITEMS) begin
         run_random_set(set_idx == 2);
         set_idx++;
      end

      // drain and settle
      req_valid <= 1'b0;
      while (answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d loads and %0d finds over %0d target settings;", loads_sent,
               finds_sent, targets_set);
      $display("%0d subsets matched, %0d mismatches seen.", hits_seen, mismatches);
      if (mismatches == 0) begin
         $display("** subset_sum_enumerator_core: PASSED **");
      end else begin
         $display("** subset_sum_enumerator_core: FAILED **");
      end
      $finish;
   end

endmodule

[sim.f]
src/sse_pkg.sv
src/sse_csr.sv
src/subset_sum_enumerator_core.sv
verif/tb_top.sv
